// ----- src/rmj_pkg.sv -----
// Package for the radar measurement Jacobian block: widths, payload types,
// divider lane type and the small arithmetic helpers used by the datapath.
// No dependencies.
package rmj_pkg;

  localparam int DataW   = 32;
  localparam int FracW   = 16;
  localparam int ProdW   = 2 * DataW;
  localparam int RemW    = DataW + 3;
  localparam int DenW    = 3 * DataW;
  localparam int NumW    = 3 * DataW + FracW;
  localparam int CmpW    = DenW + DataW;
  localparam int QuoW    = DataW - 1;
  localparam int NumLanes = 6;

  localparam int LaneRangeX   = 0;
  localparam int LaneRangeY   = 1;
  localparam int LaneBearingX = 2;
  localparam int LaneBearingY = 3;
  localparam int LaneRateX    = 4;
  localparam int LaneRateY    = 5;

  typedef struct packed {
    logic signed [DataW-1:0] pos_x;
    logic signed [DataW-1:0] pos_y;
    logic signed [DataW-1:0] vel_x;
    logic signed [DataW-1:0] vel_y;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] drange_dx;
    logic signed [DataW-1:0] drange_dy;
    logic signed [DataW-1:0] dbearing_dx;
    logic signed [DataW-1:0] dbearing_dy;
    logic signed [DataW-1:0] drate_dx;
    logic signed [DataW-1:0] drate_dy;
    logic                    zero_range_error;
  } out_item_t;

  typedef struct packed {
    logic [NumW-1:0] rem;
    logic [DenW-1:0] den;
    logic [QuoW-1:0] quo;
    logic            ovf;
    logic            neg;
  } lane_t;

  function automatic logic [DataW-1:0] mag_of(logic [DataW-1:0] raw);
    return raw[DataW-1] ? (~raw + DataW'(1)) : raw;
  endfunction

  function automatic logic [ProdW-1:0] mul_w(logic [DataW-1:0] a, logic [DataW-1:0] b);
    return ProdW'(a) * ProdW'(b);
  endfunction

  function automatic lane_t lane_init(logic [NumW-1:0] num, logic [DenW-1:0] den,
                                      logic neg);
    lane_t o;
    o.rem = num;
    o.den = den;
    o.quo = '0;
    o.neg = neg;
    o.ovf = (num >> QuoW) >= NumW'(den);
    return o;
  endfunction

  function automatic lane_t div_step(lane_t l, int unsigned i);
    lane_t           o;
    logic [CmpW-1:0] dsh;
    logic [CmpW-1:0] rx;
    o   = l;
    dsh = CmpW'(l.den) << i;
    rx  = CmpW'(l.rem);
    if (rx >= dsh) begin
      o.rem = NumW'(rx - dsh);
      o.quo = l.quo | (QuoW'(1) << i);
    end
    return o;
  endfunction

  function automatic logic [DataW-1:0] lane_result(lane_t l);
    logic [DataW-1:0] m;
    m = {1'b0, l.quo};
    if (l.ovf) begin
      return l.neg ? {1'b1, {QuoW{1'b0}}} : {1'b0, {QuoW{1'b1}}};
    end
    return l.neg ? (~m + DataW'(1)) : m;
  endfunction

endpackage

// ----- src/rmj_stream_if.sv -----
// Valid/ready stream interface carrying one payload per transaction.
// The payload type is supplied at instantiation, normally from rmj_pkg.
interface rmj_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- src/radar_measurement_jacobian.sv -----
// Radar measurement Jacobian: fully pipelined sqrt and six bit-per-stage dividers.
// Depends on rmj_pkg and rmj_stream_if.
//
//   channel   direction  payload      transaction
//   in_chan   sink       in_item_t    valid & ready
//   out_chan  source     out_item_t   valid & ready
//
// One item is accepted per cycle unless out_chan back-pressure fills the pipeline;
// the pipeline computes one root bit per stage and then one quotient bit per divider stage.
// Reset clears only the stage valid bits.
// Each stage moves when it is empty or its successor moves, so bubbles close up
// and input is taken while a finished result waits at the output register.
module radar_measurement_jacobian
  import rmj_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  rmj_stream_if.sink    in_chan,
  rmj_stream_if.source  out_chan
);

  localparam int StA   = 0;
  localparam int StB   = 1;
  localparam int StC   = 2;
  localparam int StM1  = DataW + 3;
  localparam int StM2  = DataW + 4;
  localparam int StD0  = DataW + 5;
  localparam int StOut = 2 * DataW + 5;
  localparam int NumSt = 2 * DataW + 6;

  typedef struct packed {
    logic [DataW-1:0] px, py, vx, vy;
    logic npx, npy, nvx, nvy, zero;
  } sa_t;

  typedef struct packed {
    logic [ProdW-1:0] xx, yy, pa, pb;
    logic [DataW-1:0] px, py;
    logic npx, npy, na, nb, zero;
  } sb_t;

  typedef struct packed {
    logic [ProdW-1:0] s, c;
    logic [DataW-1:0] px, py;
    logic [RemW-1:0]  rem;
    logic [DataW-1:0] root;
    logic nc, npx, npy, zero;
  } sq_t;

  typedef struct packed {
    logic [ProdW-1:0] xc_lo, xc_hi, yc_lo, yc_hi, sr_lo, sr_hi;
    logic [ProdW-1:0] s;
    logic [DataW-1:0] px, py, r;
    logic nc, npx, npy, zero;
  } m1_t;

  typedef struct packed {
    logic [DenW-1:0]  xc, yc, sr;
    logic [ProdW-1:0] s;
    logic [DataW-1:0] px, py, r;
    logic nc, npx, npy, zero;
  } m2_t;

  typedef struct packed {
    lane_t [NumLanes-1:0] ln;
    logic                 zero;
  } dv_t;

  logic [NumSt-1:0] v_r;
  logic [NumSt-1:0] en;

  sa_t       a_r, a_nxt;
  sb_t       b_r, b_nxt;
  sq_t       sq_r [0:DataW];
  sq_t       c_nxt;
  m1_t       m1_r, m1_nxt;
  m2_t       m2_r, m2_nxt;
  dv_t       dv_r [0:QuoW];
  dv_t       d0_nxt;
  out_item_t out_r, out_nxt;

  always_comb begin
    en[NumSt-1] = !v_r[NumSt-1] || out_chan.ready;
    for (int k = NumSt - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_chan.ready    = en[StA];
  assign out_chan.valid   = v_r[StOut];
  assign out_chan.payload = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[StA]) begin
        v_r[StA] <= in_chan.valid;
      end
      for (int k = 1; k < NumSt; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_comb begin
    a_nxt.px   = mag_of(in_chan.payload.pos_x);
    a_nxt.py   = mag_of(in_chan.payload.pos_y);
    a_nxt.vx   = mag_of(in_chan.payload.vel_x);
    a_nxt.vy   = mag_of(in_chan.payload.vel_y);
    a_nxt.npx  = in_chan.payload.pos_x[DataW-1];
    a_nxt.npy  = in_chan.payload.pos_y[DataW-1];
    a_nxt.nvx  = in_chan.payload.vel_x[DataW-1];
    a_nxt.nvy  = in_chan.payload.vel_y[DataW-1];
    a_nxt.zero = (in_chan.payload.pos_x == '0) && (in_chan.payload.pos_y == '0);
  end

  always_comb begin
    b_nxt.xx   = mul_w(a_r.px, a_r.px);
    b_nxt.yy   = mul_w(a_r.py, a_r.py);
    b_nxt.pa   = mul_w(a_r.vx, a_r.py);
    b_nxt.pb   = mul_w(a_r.vy, a_r.px);
    b_nxt.px   = a_r.px;
    b_nxt.py   = a_r.py;
    b_nxt.npx  = a_r.npx;
    b_nxt.npy  = a_r.npy;
    b_nxt.na   = a_r.nvx ^ a_r.npy;
    b_nxt.nb   = ~(a_r.nvy ^ a_r.npx);
    b_nxt.zero = a_r.zero;
  end

  // Cross term vx*py - vy*px is kept in sign-magnitude form.
  always_comb begin
    c_nxt.s    = b_r.xx + b_r.yy;
    c_nxt.px   = b_r.px;
    c_nxt.py   = b_r.py;
    c_nxt.npx  = b_r.npx;
    c_nxt.npy  = b_r.npy;
    c_nxt.zero = b_r.zero;
    c_nxt.rem  = '0;
    c_nxt.root = '0;
    if (b_r.na == b_r.nb) begin
      c_nxt.c  = b_r.pa + b_r.pb;
      c_nxt.nc = b_r.na;
    end else if (b_r.pa >= b_r.pb) begin
      c_nxt.c  = b_r.pa - b_r.pb;
      c_nxt.nc = b_r.na;
    end else begin
      c_nxt.c  = b_r.pb - b_r.pa;
      c_nxt.nc = b_r.nb;
    end
  end

  always_ff @(posedge clk) begin
    if (en[StA]) begin
      a_r <= a_nxt;
    end
    if (en[StB]) begin
      b_r <= b_nxt;
    end
    if (en[StC]) begin
      sq_r[0] <= c_nxt;
    end
  end

  // Square root, one result bit per stage, most significant bit first.
  for (genvar j = 1; j <= DataW; j++) begin : g_sqrt
    localparam int Bit = DataW - j;
    sq_t             st_nxt;
    logic [RemW-1:0] rsh;
    logic [RemW-1:0] trial;

    always_comb begin
      st_nxt = sq_r[j-1];
      rsh    = {sq_r[j-1].rem[RemW-3:0], sq_r[j-1].s[2*Bit +: 2]};
      trial  = RemW'({sq_r[j-1].root, 2'b01});
      if (rsh >= trial) begin
        st_nxt.rem  = rsh - trial;
        st_nxt.root = {sq_r[j-1].root[DataW-2:0], 1'b1};
      end else begin
        st_nxt.rem  = rsh;
        st_nxt.root = {sq_r[j-1].root[DataW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en[StC + j]) begin
        sq_r[j] <= st_nxt;
      end
    end
  end

  always_comb begin
    m1_nxt.xc_lo = mul_w(sq_r[DataW].px, sq_r[DataW].c[DataW-1:0]);
    m1_nxt.xc_hi = mul_w(sq_r[DataW].px, sq_r[DataW].c[ProdW-1:DataW]);
    m1_nxt.yc_lo = mul_w(sq_r[DataW].py, sq_r[DataW].c[DataW-1:0]);
    m1_nxt.yc_hi = mul_w(sq_r[DataW].py, sq_r[DataW].c[ProdW-1:DataW]);
    m1_nxt.sr_lo = mul_w(sq_r[DataW].root, sq_r[DataW].s[DataW-1:0]);
    m1_nxt.sr_hi = mul_w(sq_r[DataW].root, sq_r[DataW].s[ProdW-1:DataW]);
    m1_nxt.s     = sq_r[DataW].s;
    m1_nxt.px    = sq_r[DataW].px;
    m1_nxt.py    = sq_r[DataW].py;
    m1_nxt.r     = sq_r[DataW].root;
    m1_nxt.nc    = sq_r[DataW].nc;
    m1_nxt.npx   = sq_r[DataW].npx;
    m1_nxt.npy   = sq_r[DataW].npy;
    m1_nxt.zero  = sq_r[DataW].zero;
  end

  always_comb begin
    m2_nxt.xc   = (DenW'(m1_r.xc_hi) << DataW) + DenW'(m1_r.xc_lo);
    m2_nxt.yc   = (DenW'(m1_r.yc_hi) << DataW) + DenW'(m1_r.yc_lo);
    m2_nxt.sr   = (DenW'(m1_r.sr_hi) << DataW) + DenW'(m1_r.sr_lo);
    m2_nxt.s    = m1_r.s;
    m2_nxt.px   = m1_r.px;
    m2_nxt.py   = m1_r.py;
    m2_nxt.r    = m1_r.r;
    m2_nxt.nc   = m1_r.nc;
    m2_nxt.npx  = m1_r.npx;
    m2_nxt.npy  = m1_r.npy;
    m2_nxt.zero = m1_r.zero;
  end

  always_comb begin
    d0_nxt.zero = m2_r.zero;
    d0_nxt.ln[LaneRangeX] = lane_init(NumW'(m2_r.px) << FracW, DenW'(m2_r.r), m2_r.npx);
    d0_nxt.ln[LaneRangeY] = lane_init(NumW'(m2_r.py) << FracW, DenW'(m2_r.r), m2_r.npy);
    d0_nxt.ln[LaneBearingX] = lane_init(NumW'(m2_r.py) << (2 * FracW), DenW'(m2_r.s),
                                        ~m2_r.npy);
    d0_nxt.ln[LaneBearingY] = lane_init(NumW'(m2_r.px) << (2 * FracW), DenW'(m2_r.s),
                                        m2_r.npx);
    d0_nxt.ln[LaneRateX] = lane_init(NumW'(m2_r.yc) << FracW, m2_r.sr,
                                     m2_r.npy ^ m2_r.nc);
    d0_nxt.ln[LaneRateY] = lane_init(NumW'(m2_r.xc) << FracW, m2_r.sr,
                                     m2_r.npx ^ ~m2_r.nc);
  end

  always_ff @(posedge clk) begin
    if (en[StM1]) begin
      m1_r <= m1_nxt;
    end
    if (en[StM2]) begin
      m2_r <= m2_nxt;
    end
    if (en[StD0]) begin
      dv_r[0] <= d0_nxt;
    end
  end

  // Restoring division, one quotient bit per stage in all six lanes.
  for (genvar k = 1; k <= QuoW; k++) begin : g_div
    dv_t st_nxt;

    always_comb begin
      st_nxt.zero = dv_r[k-1].zero;
      for (int l = 0; l < NumLanes; l++) begin
        st_nxt.ln[l] = div_step(dv_r[k-1].ln[l], QuoW - k);
      end
    end

    always_ff @(posedge clk) begin
      if (en[StD0 + k]) begin
        dv_r[k] <= st_nxt;
      end
    end
  end

  always_comb begin
    out_nxt.drange_dx        = lane_result(dv_r[QuoW].ln[LaneRangeX]);
    out_nxt.drange_dy        = lane_result(dv_r[QuoW].ln[LaneRangeY]);
    out_nxt.dbearing_dx      = lane_result(dv_r[QuoW].ln[LaneBearingX]);
    out_nxt.dbearing_dy      = lane_result(dv_r[QuoW].ln[LaneBearingY]);
    out_nxt.drate_dx         = lane_result(dv_r[QuoW].ln[LaneRateX]);
    out_nxt.drate_dy         = lane_result(dv_r[QuoW].ln[LaneRateY]);
    out_nxt.zero_range_error = dv_r[QuoW].zero;
    if (dv_r[QuoW].zero) begin
      out_nxt = '0;
      out_nxt.zero_range_error = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[StOut]) begin
      out_r <= out_nxt;
    end
  end

  a_zero_outputs : assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_r.zero_range_error |->
      out_r.drange_dx == '0 && out_r.drange_dy == '0 && out_r.dbearing_dx == '0 &&
      out_r.dbearing_dy == '0 && out_r.drate_dx == '0 && out_r.drate_dy == '0)
    else $error("zero range result carries nonzero entries");

  a_range_bounded : assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_r.zero_range_error |->
      out_r.drange_dx <= $signed(DataW'(1) << FracW) &&
      out_r.drange_dx >= -$signed(DataW'(1) << FracW))
    else $error("range derivative exceeds unity");

  a_root_floor : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[StC + DataW] |->
      mul_w(sq_r[DataW].root, sq_r[DataW].root) <= sq_r[DataW].s)
    else $error("square root stage result too large");

  a_full_blocks : assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r) && !out_chan.ready |-> !in_chan.ready)
    else $error("input taken while pipeline full and stalled");

endmodule
